/* src/pulse_width_status_decoder_core_defines.svh */
// Assertion macros shared by the pulse width status decoder RTL.
// Depends on nothing; files that check their logic include it by name.
`ifndef PULSE_WIDTH_STATUS_DECODER_CORE_DEFINES_SVH
`define PULSE_WIDTH_STATUS_DECODER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define PWSD_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define PWSD_ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define PWSD_ASSERT(label, clk, rst, prop, msg)
`define PWSD_ASSERT_NEVER(label, clk, rst, cond, msg)
`endif
`endif

/* src/pwsd_pkg.sv */
// Types and constants of the pulse width status decoder.
// Used by the result channel interface, the pulse classifier and the top level.
package pwsd_pkg;

   localparam int CSR_DATA_BITS = 16;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CONFIRM_BITS = 4;
   localparam int STATUS_BITS = 3;

   typedef enum logic [STATUS_BITS-1:0] {
      STATUS_NONE        = 3'd0,
      STATUS_PUMP        = 3'd1,
      STATUS_MOTOR       = 3'd2,
      STATUS_COMPLETE    = 3'd3,
      STATUS_OVERCURRENT = 3'd4,
      STATUS_UNDERVOLT   = 3'd5
   } pwsd_status_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_PUMP_MIN        = 3'd0,
      CSR_MOTOR_MIN       = 3'd1,
      CSR_COMPLETE_MIN    = 3'd2,
      CSR_OVERCURRENT_MIN = 3'd3,
      CSR_UNDERVOLT_MIN   = 3'd4,
      CSR_UNDERVOLT_MAX   = 3'd5,
      CSR_SILENCE_TIMEOUT = 3'd6,
      CSR_CONFIRM_LIMIT   = 3'd7
   } pwsd_csr_type;

   // Pulse width thresholds handed to the classifier.
   typedef struct packed {
      logic [CSR_DATA_BITS-1:0] pump_min;
      logic [CSR_DATA_BITS-1:0] motor_min;
      logic [CSR_DATA_BITS-1:0] complete_min;
      logic [CSR_DATA_BITS-1:0] overcurrent_min;
      logic [CSR_DATA_BITS-1:0] undervolt_min;
      logic [CSR_DATA_BITS-1:0] undervolt_max;
   } pwsd_thresh_type;

   localparam logic [CSR_DATA_BITS-1:0] PUMP_MIN_RST        = 16'd100;
   localparam logic [CSR_DATA_BITS-1:0] MOTOR_MIN_RST       = 16'd200;
   localparam logic [CSR_DATA_BITS-1:0] COMPLETE_MIN_RST    = 16'd300;
   localparam logic [CSR_DATA_BITS-1:0] OVERCURRENT_MIN_RST = 16'd400;
   localparam logic [CSR_DATA_BITS-1:0] UNDERVOLT_MIN_RST   = 16'd500;
   localparam logic [CSR_DATA_BITS-1:0] UNDERVOLT_MAX_RST   = 16'd600;
   localparam logic [CSR_DATA_BITS-1:0] SILENCE_TIMEOUT_RST = 16'd3000;
   localparam logic [CONFIRM_BITS-1:0]  CONFIRM_LIMIT_RST   = 4'd2;

endpackage

/* src/pwsd_req_if.sv */
// Sample channel of the pulse width status decoder.
// Depends on nothing beyond the language; carries one pin sample per word.
interface pwsd_req_if;
   logic valid;
   logic ready;
   logic pin_level;
   logic charging;

   modport source (output valid, output pin_level, output charging, input ready);
   modport sink (input valid, input pin_level, input charging, output ready);
endinterface

/* src/pwsd_rsp_if.sv */
// Result channel of the pulse width status decoder.
// Depends on pwsd_pkg for the width of the status codes.
interface pwsd_rsp_if
   import pwsd_pkg::*;
;
   logic valid;
   logic ready;
   logic [STATUS_BITS-1:0] board_status;
   logic stop_request;
   logic [STATUS_BITS-1:0] seen_class;

   modport source (output valid, output board_status, output stop_request,
                   output seen_class, input ready);
   modport sink (input valid, input board_status, input stop_request,
                 input seen_class, output ready);
endinterface

/* src/pwsd_classify.sv */
// Sorts a measured high pulse width into a status bin.
// Depends on pwsd_pkg for the threshold struct and the status codes.
module pwsd_classify
   import pwsd_pkg::*;
#(
   parameter int AGE_BITS = 16
) (
   input  logic [AGE_BITS-1:0] width,
   input  pwsd_thresh_type     thresh,
   output pwsd_status_type     bin
);

   localparam int CMP_BITS = (AGE_BITS > CSR_DATA_BITS) ? AGE_BITS : CSR_DATA_BITS;

   logic [CMP_BITS-1:0] w;

   assign w = CMP_BITS'(width);

   // Under voltage is a window and takes priority over the plain minimums.
   always_comb begin
      if (w >= CMP_BITS'(thresh.undervolt_min) && w < CMP_BITS'(thresh.undervolt_max)) begin
         bin = STATUS_UNDERVOLT;
      end else if (w >= CMP_BITS'(thresh.overcurrent_min)) begin
         bin = STATUS_OVERCURRENT;
      end else if (w >= CMP_BITS'(thresh.complete_min)) begin
         bin = STATUS_COMPLETE;
      end else if (w >= CMP_BITS'(thresh.motor_min)) begin
         bin = STATUS_MOTOR;
      end else if (w >= CMP_BITS'(thresh.pump_min)) begin
         bin = STATUS_PUMP;
      end else begin
         bin = STATUS_NONE;
      end
   end

endmodule

/* src/pulse_width_status_decoder_core.sv */
// Top level of the pulse width status decoder.
// Depends on pwsd_pkg, pwsd_req_if, pwsd_rsp_if, pwsd_classify and the defines header.
//
// Usage: every word on the req_chan channel is one tick of the feedback pin,
// carrying the sampled pin level and the charging flag. For every accepted
// word the block returns exactly one word on rsp_chan: the board status after
// that tick, a stop request when the silence timeout fired, and the bin of
// the high pulse that ended in that tick (none when no pulse ended).
// A word accepted at one clock edge is presented on rsp_chan from the next
// edge on. One word is taken per cycle while rsp_chan is ready; the
// whole tick update (age counters, pulse binning, confirm counter, timeout
// check) is a single combinational pass into the result register and the
// age and status registers.
// When the receiver stalls, the result register holds its word and req_chan
// ready stays low until the word is taken; in the cycle it is taken, a new
// sample can be accepted, so a continuously ready receiver sees no bubbles.
// Reset is synchronous and active high. It clears both ages, the confirm
// counter and the status, drops the result valid, and restores all
// threshold registers to their defaults. The user must write thresholds through
// the csr_ port only while no sample is in flight; the block does not enforce it.
`include "pulse_width_status_decoder_core_defines.svh"

module pulse_width_status_decoder_core
   import pwsd_pkg::*;
#(
   parameter int AGE_BITS = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   pwsd_req_if.sink                  req_chan,
   pwsd_rsp_if.source                rsp_chan,
   input  logic                      csr_write_en,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   localparam int CMP_BITS = (AGE_BITS > CSR_DATA_BITS) ? AGE_BITS : CSR_DATA_BITS;
   localparam logic [AGE_BITS-1:0] AGE_MAX = {AGE_BITS{1'b1}};

   // Configuration registers.
   pwsd_thresh_type          thresh_ff;
   logic [CSR_DATA_BITS-1:0] timeout_ff;
   logic [CONFIRM_BITS-1:0]  limit_ff;

   // Tick state.
   logic [AGE_BITS-1:0]     since_high_ff, since_high_in;
   logic [AGE_BITS-1:0]     since_low_ff, since_low_in;
   logic [CONFIRM_BITS-1:0] confirm_ff, confirm_in;
   pwsd_status_type         status_ff, status_in;

   // Result register.
   logic            rsp_valid_ff, rsp_valid_in;
   pwsd_status_type rsp_status_ff;
   logic            rsp_stop_ff, stop_in;
   pwsd_status_type rsp_seen_ff, seen_in;

   logic                accept;
   logic [AGE_BITS-1:0] high_up;
   logic [AGE_BITS-1:0] low_up;
   pwsd_status_type     bin;

   // A sample is taken whenever the result register is empty or being drained.
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept = req_chan.valid && req_chan.ready;

   // Both ages count up first and saturate at all ones.
   assign high_up = (since_high_ff == AGE_MAX) ? since_high_ff : since_high_ff + 1'b1;
   assign low_up  = (since_low_ff == AGE_MAX) ? since_low_ff : since_low_ff + 1'b1;

   // The since-low age is the width of the high pulse that a low sample ends.
   pwsd_classify #(
      .AGE_BITS (AGE_BITS)
   ) u_classify (
      .width  (low_up),
      .thresh (thresh_ff),
      .bin    (bin)
   );

   // One tick of the decoder.
   always_comb begin
      since_high_in = high_up;
      since_low_in  = low_up;
      confirm_in    = confirm_ff;
      status_in     = status_ff;
      seen_in       = STATUS_NONE;
      stop_in       = 1'b0;
      if (req_chan.charging) begin
         // Charging clears both ages and leaves status and confirm alone.
         since_high_in = '0;
         since_low_in  = '0;
      end else begin
         if (req_chan.pin_level) begin
            since_high_in = '0;
         end else begin
            seen_in = bin;
            // A differing, nonzero bin steps the shared confirm counter and
            // is adopted once the counter has reached the limit.
            if (bin != STATUS_NONE && bin != status_ff) begin
               if (confirm_ff == limit_ff) begin
                  confirm_in = '0;
                  status_in  = bin;
               end else begin
                  confirm_in = confirm_ff + 1'b1;
               end
            end
            since_low_in = '0;
         end
         // Silence on either level drops the status and asks for a stop.
         if (CMP_BITS'(since_low_in) > CMP_BITS'(timeout_ff)
             || CMP_BITS'(since_high_in) > CMP_BITS'(timeout_ff)) begin
            status_in = STATUS_NONE;
            stop_in   = 1'b1;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff.pump_min        <= PUMP_MIN_RST;
         thresh_ff.motor_min       <= MOTOR_MIN_RST;
         thresh_ff.complete_min    <= COMPLETE_MIN_RST;
         thresh_ff.overcurrent_min <= OVERCURRENT_MIN_RST;
         thresh_ff.undervolt_min   <= UNDERVOLT_MIN_RST;
         thresh_ff.undervolt_max   <= UNDERVOLT_MAX_RST;
         timeout_ff                <= SILENCE_TIMEOUT_RST;
         limit_ff                  <= CONFIRM_LIMIT_RST;
      end else if (csr_write_en) begin
         unique case (pwsd_csr_type'(csr_index))
            CSR_PUMP_MIN:        thresh_ff.pump_min        <= csr_wdata;
            CSR_MOTOR_MIN:       thresh_ff.motor_min       <= csr_wdata;
            CSR_COMPLETE_MIN:    thresh_ff.complete_min    <= csr_wdata;
            CSR_OVERCURRENT_MIN: thresh_ff.overcurrent_min <= csr_wdata;
            CSR_UNDERVOLT_MIN:   thresh_ff.undervolt_min   <= csr_wdata;
            CSR_UNDERVOLT_MAX:   thresh_ff.undervolt_max   <= csr_wdata;
            CSR_SILENCE_TIMEOUT: timeout_ff                <= csr_wdata;
            CSR_CONFIRM_LIMIT:   limit_ff                  <= csr_wdata[CONFIRM_BITS-1:0];
            default: ;
         endcase
      end
   end

   // Tick state and result valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         since_high_ff <= '0;
         since_low_ff  <= '0;
         confirm_ff    <= '0;
         status_ff     <= STATUS_NONE;
         rsp_valid_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            since_high_ff <= since_high_in;
            since_low_ff  <= since_low_in;
            confirm_ff    <= confirm_in;
            status_ff     <= status_in;
         end
      end
   end

   // Result payload, loaded with the word of each accepted sample.
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_status_ff <= status_in;
         rsp_stop_ff   <= stop_in;
         rsp_seen_ff   <= seen_in;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.board_status = rsp_status_ff;
   assign rsp_chan.stop_request = rsp_stop_ff;
   assign rsp_chan.seen_class   = rsp_seen_ff;

   // A stop request always comes with the status dropped to none.
   `PWSD_ASSERT(a_stop_clears_status, clock, reset,
      (rsp_valid_ff && rsp_stop_ff) |-> (rsp_status_ff == STATUS_NONE),
      "stop request issued with a live status")

   // A new nonzero status is only adopted together with a cleared confirm count.
   `PWSD_ASSERT(a_adopt_clears_confirm, clock, reset,
      (status_ff != $past(status_ff) && status_ff != STATUS_NONE) |-> (confirm_ff == '0),
      "status adopted without clearing the confirm counter")

   // A charging sample leaves both ages at zero.
   `PWSD_ASSERT(a_charging_clears_ages, clock, reset,
      (accept && req_chan.charging) |=> (since_high_ff == '0 && since_low_ff == '0),
      "ages not cleared by a charging sample")

endmodule
